FILE: hdl/hkc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkc_pkg
// Shared types, codes and default sizes for the hashed key counter table.
// ----------------------------------------------------------------------------
package hkc_pkg;

    // default table geometry
    localparam int HKC_BUCKETS  = 7;
    localparam int HKC_WAYS     = 4;
    localparam int HKC_KEY_BITS = 32;

    // fixed field widths
    localparam int CMD_W    = 2;
    localparam int KEY_W    = 32;
    localparam int COUNT_W  = 16;
    localparam int STATUS_W = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WATCH  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_WATCHED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd5;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd6;

    // input beat
    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] initial_count;
    } in_item_t;

    // output beat
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } out_item_t;

    // controller to datapath commands
    typedef struct packed {
        logic clear_wr;
        logic load_in;
        logic hash_step;
        logic base_load;
        logic check;
        logic apply;
    } ctl_t;

    // datapath to controller status
    typedef struct packed {
        logic clear_last;
        logic hash_last;
        logic way_last;
        logic match;
        logic out_busy;
    } sts_t;

endpackage

FILE: hdl/hkc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkc_ctrl
// Sequencer for the table: clearing pass, key hashing, bucket scan, update.
// ----------------------------------------------------------------------------
module hkc_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    output hkc_pkg::ctl_t ctl,
    input  hkc_pkg::sts_t sts
);
    import hkc_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_HASH  = 7'b0000100,
        S_BASE  = 7'b0001000,
        S_READ  = 7'b0010000,
        S_CHECK = 7'b0100000,
        S_APPLY = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        cmd_ready  = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.clear_wr = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    ctl.load_in = 1'b1;
                    state_next  = S_HASH;
                end
            end
            S_HASH:
            begin
                ctl.hash_step = 1'b1;
                if (sts.hash_last)
                begin
                    state_next = S_BASE;
                end
            end
            S_BASE:
            begin
                ctl.base_load = 1'b1;
                state_next    = S_READ;
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                ctl.check = 1'b1;
                if (sts.match || sts.way_last)
                begin
                    state_next = S_APPLY;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_APPLY:
            begin
                if (!sts.out_busy)
                begin
                    ctl.apply  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

FILE: hdl/hkc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkc_datapath
// Entry memory, modulo hash unit, bucket scan registers and result register.
// ----------------------------------------------------------------------------
module hkc_datapath
#(
    parameter int BUCKETS  = hkc_pkg::HKC_BUCKETS,
    parameter int WAYS     = hkc_pkg::HKC_WAYS,
    parameter int KEY_BITS = hkc_pkg::HKC_KEY_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  hkc_pkg::in_item_t  cmd,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output hkc_pkg::out_item_t rsp,
    input  hkc_pkg::ctl_t      ctl,
    output hkc_pkg::sts_t      sts
);
    import hkc_pkg::*;

    localparam int KW      = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int HSTEPS  = (KW + 7) / 8;
    localparam int KPAD    = HSTEPS * 8;
    localparam int HCW     = (HSTEPS > 1) ? $clog2(HSTEPS) : 1;
    localparam int ENTRIES = BUCKETS * WAYS;
    localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WW      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int MW      = 1 + KW + COUNT_W;

    localparam logic [RW:0]   BUCKETS_T  = (RW + 1)'(BUCKETS);
    localparam logic [HCW-1:0] HLAST     = HCW'(HSTEPS - 1);
    localparam logic [WW-1:0]  WAY_LAST  = WW'(WAYS - 1);
    localparam logic [AW-1:0]  ENT_LAST  = AW'(ENTRIES - 1);

    // entry memory: {valid, key, count}
    logic [MW-1:0] mem [ENTRIES];
    logic [MW-1:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [MW-1:0] wr_data;
    logic          wr_en;

    // latched command
    logic [CMD_W-1:0]   command_reg;
    logic [KW-1:0]      key_reg;
    logic [COUNT_W-1:0] init_reg;

    // hash unit
    logic [KPAD-1:0] key_sh_reg;
    logic [HCW-1:0]  hcnt_reg;
    logic [RW-1:0]   rem_reg;
    logic [RW-1:0]   rem_next;

    // scan state
    logic [AW-1:0]      clr_addr_reg;
    logic [AW-1:0]      base_reg;
    logic [WW-1:0]      way_reg;
    logic               hit_reg;
    logic [WW-1:0]      hit_way_reg;
    logic [COUNT_W-1:0] hit_cnt_reg;
    logic               free_reg;
    logic [WW-1:0]      free_way_reg;

    // read word fields
    logic               rd_valid;
    logic [KW-1:0]      rd_key;
    logic [COUNT_W-1:0] rd_cnt;
    logic               match;

    // result
    logic               rsp_valid_reg;
    out_item_t          rsp_reg;
    out_item_t          result;
    logic [COUNT_W-1:0] sat_cnt;
    logic               apply_wr;
    logic [MW-1:0]      apply_data;

    // eight restoring steps of key mod BUCKETS, one byte per cycle
    always_comb
    begin
        logic [RW:0]  t;
        logic [7:0]   digit;
        logic [RW-1:0] r;
        digit = key_sh_reg[KPAD-1 -: 8];
        r     = rem_reg;
        for (int i = 0; i < 8; i++)
        begin
            t = {r, digit[7-i]};
            if (t >= BUCKETS_T)
            begin
                t = t - BUCKETS_T;
            end
            r = t[RW-1:0];
        end
        rem_next = r;
    end

    // hash and command registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            command_reg <= '0;
            hcnt_reg    <= '0;
            rem_reg     <= '0;
        end
        else if (ctl.load_in)
        begin
            command_reg <= cmd.command;
            hcnt_reg    <= '0;
            rem_reg     <= '0;
        end
        else if (ctl.hash_step)
        begin
            hcnt_reg <= hcnt_reg + HCW'(1);
            rem_reg  <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_in)
        begin
            key_reg     <= cmd.key[KW-1:0];
            init_reg    <= cmd.initial_count;
            key_sh_reg  <= KPAD'(cmd.key[KW-1:0]);
        end
        else if (ctl.hash_step)
        begin
            key_sh_reg <= key_sh_reg << 8;
        end
    end

    // clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (ctl.clear_wr)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    // read word decode
    assign rd_valid = rd_data_reg[MW-1];
    assign rd_key   = rd_data_reg[COUNT_W +: KW];
    assign rd_cnt   = rd_data_reg[COUNT_W-1:0];
    assign match    = rd_valid && (rd_key == key_reg);

    // bucket scan registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            way_reg  <= '0;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        else if (ctl.base_load)
        begin
            base_reg <= AW'(rem_reg * WAYS);
            way_reg  <= '0;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        else if (ctl.check)
        begin
            way_reg <= way_reg + WW'(1);
            if (match)
            begin
                hit_reg <= 1'b1;
            end
            else if (!rd_valid && !free_reg)
            begin
                free_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.check)
        begin
            if (match)
            begin
                hit_way_reg <= way_reg;
                hit_cnt_reg <= rd_cnt;
            end
            if (!rd_valid && !free_reg)
            begin
                free_way_reg <= way_reg;
            end
        end
    end

    // result and write-back
    assign sat_cnt = (hit_cnt_reg == COUNT_MAX) ? hit_cnt_reg : hit_cnt_reg + COUNT_W'(1);

    always_comb
    begin
        result     = '0;
        apply_wr   = 1'b0;
        apply_data = {1'b1, key_reg, init_reg};
        unique case (command_reg)
            CMD_INSERT:
            begin
                if (hit_reg)
                begin
                    result.status = ST_DUP;
                    result.count  = hit_cnt_reg;
                end
                else if (free_reg)
                begin
                    result.status = ST_ADDED;
                    result.count  = init_reg;
                    apply_wr      = 1'b1;
                end
                else
                begin
                    result.status = ST_FULL;
                end
            end
            CMD_WATCH:
            begin
                if (hit_reg)
                begin
                    result.status = ST_WATCHED;
                    result.count  = sat_cnt;
                    apply_wr      = 1'b1;
                    apply_data    = {1'b1, key_reg, sat_cnt};
                end
                else
                begin
                    result.status = ST_NOTFOUND;
                end
            end
            CMD_REMOVE:
            begin
                if (hit_reg)
                begin
                    result.status = ST_REMOVED;
                    apply_wr      = 1'b1;
                    apply_data    = {1'b0, key_reg, hit_cnt_reg};
                end
                else
                begin
                    result.status = ST_NOTFOUND;
                end
            end
            CMD_LOOKUP:
            begin
                if (hit_reg)
                begin
                    result.status = ST_FOUND;
                    result.count  = hit_cnt_reg;
                end
                else
                begin
                    result.status = ST_NOTFOUND;
                end
            end
        endcase
    end

    // memory port selection
    assign rd_addr = base_reg + AW'(way_reg);
    assign wr_en   = ctl.clear_wr || (ctl.apply && apply_wr);
    assign wr_addr = ctl.clear_wr ? clr_addr_reg
                                  : base_reg + AW'(hit_reg ? hit_way_reg : free_way_reg);
    assign wr_data = ctl.clear_wr ? '0 : apply_data;

    // entry memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (ctl.apply)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.apply)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // status to controller
    assign sts.clear_last = (clr_addr_reg == ENT_LAST);
    assign sts.hash_last  = (hcnt_reg == HLAST);
    assign sts.way_last   = (way_reg == WAY_LAST);
    assign sts.match      = match;
    assign sts.out_busy   = rsp_valid_reg && !rsp_ready;

    // checks
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.base_load |-> (rem_reg < BUCKETS))
        else $error("hash remainder out of range");

    a_way_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.check |-> (way_reg <= WAY_LAST))
        else $error("scan ran past the last way");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.apply |-> !(rsp_valid_reg && !rsp_ready))
        else $error("result loaded over a stalled beat");

    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(ctl.apply))
        else $error("result raised without an update");

endmodule

FILE: hdl/hashed_key_counter_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_key_counter_table
// Bucketed key/count table hashed by key modulo the bucket count.
// ----------------------------------------------------------------------------
// Usage:
// - cmd channel (cmd_valid/cmd_ready/cmd) carries insert, watch, remove or
//   look up with a key and an initial count; rsp channel returns one beat
//   with status and count for every command, in order.
// - One command is worked at a time. The modulo unit folds in one key byte
//   per cycle over the ceil(KW/8) bytes of the key, KW = min(KEY_BITS, 32);
//   then the ways of the bucket are read in turn (scan stops at a hit, else
//   reads all WAYS), each way with a memory read state and a compare state
//   on the single read port. The result is loaded into the output register
//   in the update state. cmd_ready rises together with rsp_valid.
// - After reset a clearing pass zeroes all BUCKETS*WAYS entries of the entry
//   memory; cmd_ready stays low until it is done.
// - If the receiver stalls, the result waits in the output register and the
//   next command is still accepted and worked; it waits only before loading
//   its own result.
// ----------------------------------------------------------------------------
module hashed_key_counter_table
#(
    parameter int BUCKETS  = hkc_pkg::HKC_BUCKETS,
    parameter int WAYS     = hkc_pkg::HKC_WAYS,
    parameter int KEY_BITS = hkc_pkg::HKC_KEY_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  hkc_pkg::in_item_t  cmd,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output hkc_pkg::out_item_t rsp
);
    import hkc_pkg::*;

    ctl_t ctl;
    sts_t sts;

    // sequencer
    hkc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .ctl       (ctl),
        .sts       (sts)
    );

    // table storage and arithmetic
    hkc_datapath
    #(
        .BUCKETS  (BUCKETS),
        .WAYS     (WAYS),
        .KEY_BITS (KEY_BITS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .ctl       (ctl),
        .sts       (sts)
    );

endmodule
